// ===== sv/oa2d_pkg.sv =====
// shared types, widths, constants and arctangent table for the angle-to-direction block
// no dependencies; imported by oa2d_ctrl, oa2d_dp and orbit_angle_to_direction
package oa2d_pkg;

    // cordic iteration count, capped at the arctangent table size
    localparam int CORDIC_STEPS = 14;
    localparam int ATAN_ENTRIES = 20;
    localparam int NUM_ITER     = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
    localparam int ITER_W       = $clog2(NUM_ITER);
    localparam int ATAN_IDX_W   = $clog2(ATAN_ENTRIES);

    // field and datapath widths
    localparam int ANG_W      = 16;
    localparam int ANGX_W     = 17;
    localparam int EL_CFG_W   = 14;
    localparam int RAD_W      = 16;
    localparam int OUT_W      = 17;
    localparam int CW         = 27;
    localparam int ZW         = 28;
    localparam int PROD_W     = 2 * CW;
    localparam int RND_W      = 30;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // angle constants in q4.12
    localparam logic signed [ANGX_W-1:0] TWO_PI_Q12  = 17'sd25736;
    localparam logic signed [ANGX_W-1:0] FOUR_PI_Q12 = 17'sd51472;
    localparam logic signed [ANGX_W-1:0] PI_Q12      = 17'sd12868;
    localparam logic signed [ANGX_W-1:0] HALF_PI_Q12 = 17'sd6434;

    // cordic gain in q.24 and output limit
    localparam logic signed [CW-1:0]    GAIN_Q24  = 27'sd10188014;
    localparam logic signed [RND_W-1:0] OUT_LIMIT = 30'sd65535;
    localparam logic [RAD_W-1:0]        RADIUS_RESET = 16'd256;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_AZ = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_EL = 2'd2;

    typedef enum logic [1:0] {
        OP_RESTART = 2'd0,
        OP_ROT_AZ  = 2'd1,
        OP_ROT_EL  = 2'd2
    } t_opcode;

    typedef enum logic {
        ANG_AZ = 1'b0,
        ANG_EL = 1'b1
    } t_ang_sel;

    typedef enum logic [2:0] {
        MUL_SAZ_CEL = 3'd0,
        MUL_CAZ_CEL = 3'd1,
        MUL_FX_RAD  = 3'd2,
        MUL_SEL_RAD = 3'd3,
        MUL_FZ_RAD  = 3'd4
    } t_mul_sel;

    // commands from the controller to the datapath
    typedef struct packed {
        logic              load_in;
        logic              upd;
        logic              cordic_init;
        t_ang_sel          ang_sel;
        logic              cordic_step;
        logic [ITER_W-1:0] iter;
        logic              save_az;
        logic              save_el;
        logic              mul_en;
        t_mul_sel          mul_sel;
        logic              round_fx;
        logic              round_fz;
        logic              hold_dx;
        logic              hold_dy;
        logic              out_load;
    } t_dp_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic out_free;
    } t_dp_sts;

    // arctangent of 2^-i in q.24
    function automatic logic [23:0] atan_q24(input logic [ATAN_IDX_W-1:0] idx);
        logic [23:0] v;
        unique case (idx)
            5'd0:    v = 24'd13176795;
            5'd1:    v = 24'd7778716;
            5'd2:    v = 24'd4110060;
            5'd3:    v = 24'd2086331;
            5'd4:    v = 24'd1047214;
            5'd5:    v = 24'd524117;
            5'd6:    v = 24'd262123;
            5'd7:    v = 24'd131069;
            5'd8:    v = 24'd65536;
            5'd9:    v = 24'd32768;
            5'd10:   v = 24'd16384;
            5'd11:   v = 24'd8192;
            5'd12:   v = 24'd4096;
            5'd13:   v = 24'd2048;
            5'd14:   v = 24'd1024;
            5'd15:   v = 24'd512;
            5'd16:   v = 24'd256;
            5'd17:   v = 24'd128;
            5'd18:   v = 24'd64;
            5'd19:   v = 24'd32;
            default: v = 24'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== sv/oa2d_ctrl.sv =====
// controller state machine: sequences angle update, two cordic runs and five products
// depends on oa2d_pkg; drives oa2d_dp through t_dp_cmd
module oa2d_ctrl import oa2d_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);

    typedef enum logic [12:0] {
        S_IDLE    = 13'b0000000000001,
        S_UPD     = 13'b0000000000010,
        S_INIT_AZ = 13'b0000000000100,
        S_ROT_AZ  = 13'b0000000001000,
        S_INIT_EL = 13'b0000000010000,
        S_ROT_EL  = 13'b0000000100000,
        S_SAVE_EL = 13'b0000001000000,
        S_MUL1    = 13'b0000010000000,
        S_MUL2    = 13'b0000100000000,
        S_MUL3    = 13'b0001000000000,
        S_MUL4    = 13'b0010000000000,
        S_MUL5    = 13'b0100000000000,
        S_MUL6    = 13'b1000000000000
    } t_state;

    t_state            r_state, n_state;
    logic [ITER_W-1:0] r_iter, n_iter;
    logic              iter_last;

    assign o_in_ready = (r_state == S_IDLE);
    assign iter_last  = (r_iter == ITER_W'(NUM_ITER - 1));

    // next state and command decode
    always_comb begin
        n_state = r_state;
        n_iter  = r_iter;
        o_cmd   = '0;
        o_cmd.iter = r_iter;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_UPD;
                end
            end
            S_UPD: begin
                o_cmd.upd = 1'b1;
                n_state   = S_INIT_AZ;
            end
            S_INIT_AZ: begin
                o_cmd.cordic_init = 1'b1;
                o_cmd.ang_sel     = ANG_AZ;
                n_iter            = '0;
                n_state           = S_ROT_AZ;
            end
            S_ROT_AZ: begin
                o_cmd.cordic_step = 1'b1;
                n_iter            = r_iter + ITER_W'(1);
                if (iter_last) begin
                    n_state = S_INIT_EL;
                end
            end
            S_INIT_EL: begin
                o_cmd.save_az     = 1'b1;
                o_cmd.cordic_init = 1'b1;
                o_cmd.ang_sel     = ANG_EL;
                n_iter            = '0;
                n_state           = S_ROT_EL;
            end
            S_ROT_EL: begin
                o_cmd.cordic_step = 1'b1;
                n_iter            = r_iter + ITER_W'(1);
                if (iter_last) begin
                    n_state = S_SAVE_EL;
                end
            end
            S_SAVE_EL: begin
                o_cmd.save_el = 1'b1;
                n_state       = S_MUL1;
            end
            S_MUL1: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_SAZ_CEL;
                n_state       = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.round_fx = 1'b1;
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_sel  = MUL_CAZ_CEL;
                n_state        = S_MUL3;
            end
            S_MUL3: begin
                o_cmd.round_fz = 1'b1;
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_sel  = MUL_FX_RAD;
                n_state        = S_MUL4;
            end
            S_MUL4: begin
                o_cmd.hold_dx = 1'b1;
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_SEL_RAD;
                n_state       = S_MUL5;
            end
            S_MUL5: begin
                o_cmd.hold_dy = 1'b1;
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_FZ_RAD;
                n_state       = S_MUL6;
            end
            S_MUL6: begin
                // wait for the output register to free up
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_iter  <= '0;
        end else begin
            r_state <= n_state;
            r_iter  <= n_iter;
        end
    end

    // output register is never overwritten while a beat still waits
    a_out_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_sts.out_free)
        else $error("result loaded while output register busy");

    // iteration count stays inside the table while rotating
    a_iter_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROT_AZ || r_state == S_ROT_EL) |-> (r_iter <= ITER_W'(NUM_ITER - 1)))
        else $error("cordic iteration out of range");

    // an accepted beat always starts with the angle update
    a_accept_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_UPD))
        else $error("accepted beat did not start update");

endmodule

// ===== sv/oa2d_dp.sv =====
// datapath: config registers, angle state, shared cordic unit, shared multiplier, output register
// depends on oa2d_pkg; commanded by oa2d_ctrl
module oa2d_dp import oa2d_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_dp_cmd                      i_cmd,
    output t_dp_sts                      o_sts,
    input  logic [1:0]                   i_opcode,
    input  logic signed [ANG_W-1:0]      i_angle_step,
    input  logic                         i_cfg_we,
    input  logic [CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]        i_cfg_data,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic signed [OUT_W-1:0]      o_dir_x,
    output logic signed [OUT_W-1:0]      o_dir_y,
    output logic signed [OUT_W-1:0]      o_dir_z
);

    logic [RAD_W-1:0]           r_radius;
    logic signed [ANG_W-1:0]    r_start_az;
    logic signed [EL_CFG_W-1:0] r_start_el;
    logic [1:0]                 r_op;
    logic signed [ANG_W-1:0]    r_step;
    logic signed [ANG_W-1:0]    r_az, r_el;

    logic signed [ANGX_W-1:0]   az_sum, az_wrap, el_sum, start_el_x;

    logic signed [ANGX_W-1:0]   ang_src, ang_pre, ang_fold;
    logic                       fold_neg;
    logic signed [ZW-1:0]       z_init, atan_v;
    logic signed [CW-1:0]       r_cx, r_cy;
    logic signed [ZW-1:0]       r_cz;
    logic                       r_neg;
    logic signed [CW-1:0]       dx, dy, sin_v, cos_v;
    logic signed [CW-1:0]       r_s_az, r_c_az, r_s_el, r_c_el;

    logic signed [CW-1:0]       mul_a, mul_b, rad_x;
    logic signed [PROD_W-1:0]   r_prod, prod_sh;
    logic signed [RND_W-1:0]    rnd;
    logic signed [OUT_W-1:0]    sat;
    logic signed [CW-1:0]       r_fx, r_fz;
    logic signed [OUT_W-1:0]    r_dx, r_dy;
    logic signed [OUT_W-1:0]    r_out_x, r_out_y, r_out_z;
    logic                       r_out_valid;

    // clamp to plus or minus pi/2
    function automatic logic signed [ANG_W-1:0] clamp_el(input logic signed [ANGX_W-1:0] v);
        logic signed [ANGX_W-1:0] c;
        if (v > HALF_PI_Q12) begin
            c = HALF_PI_Q12;
        end else if (v < -HALF_PI_Q12) begin
            c = -HALF_PI_Q12;
        end else begin
            c = v;
        end
        return c[ANG_W-1:0];
    endfunction

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius   <= RADIUS_RESET;
            r_start_az <= '0;
            r_start_el <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_RADIUS:   r_radius   <= i_cfg_data;
                CFG_START_AZ: r_start_az <= i_cfg_data;
                CFG_START_EL: r_start_el <= i_cfg_data[EL_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // input beat capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_op   <= i_opcode;
            r_step <= i_angle_step;
        end
    end

    // angle update: azimuth wraps toward zero, elevation clamps
    assign az_sum     = {r_az[ANG_W-1], r_az} + {r_step[ANG_W-1], r_step};
    assign el_sum     = {r_el[ANG_W-1], r_el} + {r_step[ANG_W-1], r_step};
    assign start_el_x = {{(ANGX_W - EL_CFG_W){r_start_el[EL_CFG_W-1]}}, r_start_el};

    always_comb begin
        if (az_sum >= FOUR_PI_Q12) begin
            az_wrap = az_sum - FOUR_PI_Q12;
        end else if (az_sum >= TWO_PI_Q12) begin
            az_wrap = az_sum - TWO_PI_Q12;
        end else if (az_sum <= -FOUR_PI_Q12) begin
            az_wrap = az_sum + FOUR_PI_Q12;
        end else if (az_sum <= -TWO_PI_Q12) begin
            az_wrap = az_sum + TWO_PI_Q12;
        end else begin
            az_wrap = az_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_az <= '0;
            r_el <= '0;
        end else if (i_cmd.upd) begin
            unique case (t_opcode'(r_op))
                OP_RESTART: begin
                    r_az <= r_start_az;
                    r_el <= clamp_el(start_el_x);
                end
                OP_ROT_AZ: r_az <= az_wrap[ANG_W-1:0];
                OP_ROT_EL: r_el <= clamp_el(el_sum);
                default: ;
            endcase
        end
    end

    // cordic range reduction: into [-pi, pi], then fold into [-pi/2, pi/2]
    assign ang_src = (i_cmd.ang_sel == ANG_AZ) ? {r_az[ANG_W-1], r_az} : {r_el[ANG_W-1], r_el};

    always_comb begin
        if (ang_src > PI_Q12) begin
            ang_pre = ang_src - TWO_PI_Q12;
        end else if (ang_src < -PI_Q12) begin
            ang_pre = ang_src + TWO_PI_Q12;
        end else begin
            ang_pre = ang_src;
        end
        fold_neg = 1'b0;
        if (ang_pre > HALF_PI_Q12) begin
            ang_fold = ang_pre - PI_Q12;
            fold_neg = 1'b1;
        end else if (ang_pre < -HALF_PI_Q12) begin
            ang_fold = ang_pre + PI_Q12;
            fold_neg = 1'b1;
        end else begin
            ang_fold = ang_pre;
        end
    end

    assign z_init = {ang_fold[ANG_W-1:0], 12'b0};

    // one rotation step per cycle
    assign dx     = r_cy >>> i_cmd.iter;
    assign dy     = r_cx >>> i_cmd.iter;
    assign atan_v = {4'b0, atan_q24(ATAN_IDX_W'(i_cmd.iter))};

    always_ff @(posedge i_clk) begin
        if (i_cmd.cordic_init) begin
            r_cx  <= GAIN_Q24;
            r_cy  <= '0;
            r_cz  <= z_init;
            r_neg <= fold_neg;
        end else if (i_cmd.cordic_step) begin
            if (!r_cz[ZW-1]) begin
                r_cx <= r_cx - dx;
                r_cy <= r_cy + dy;
                r_cz <= r_cz - atan_v;
            end else begin
                r_cx <= r_cx + dx;
                r_cy <= r_cy - dy;
                r_cz <= r_cz + atan_v;
            end
        end
    end

    // undo the fold and keep sine and cosine
    assign sin_v = r_neg ? -r_cy : r_cy;
    assign cos_v = r_neg ? -r_cx : r_cx;

    always_ff @(posedge i_clk) begin
        if (i_cmd.save_az) begin
            r_s_az <= sin_v;
            r_c_az <= cos_v;
        end
        if (i_cmd.save_el) begin
            r_s_el <= sin_v;
            r_c_el <= cos_v;
        end
    end

    // shared multiplier operand select
    assign rad_x = {{(CW - RAD_W){1'b0}}, r_radius};

    always_comb begin
        unique case (i_cmd.mul_sel)
            MUL_SAZ_CEL: begin mul_a = r_s_az; mul_b = r_c_el; end
            MUL_CAZ_CEL: begin mul_a = r_c_az; mul_b = r_c_el; end
            MUL_FX_RAD:  begin mul_a = r_fx;   mul_b = rad_x;  end
            MUL_SEL_RAD: begin mul_a = r_s_el; mul_b = rad_x;  end
            MUL_FZ_RAD:  begin mul_a = r_fz;   mul_b = rad_x;  end
            default:     begin mul_a = '0;     mul_b = '0;     end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prod <= mul_a * mul_b;
        end
    end

    // round to nearest by 2^24, ties upward, then saturate
    assign prod_sh = (r_prod + PROD_W'(64'sd8388608)) >>> 24;
    assign rnd     = prod_sh[RND_W-1:0];

    always_comb begin
        if (rnd > OUT_LIMIT) begin
            sat = OUT_LIMIT[OUT_W-1:0];
        end else if (rnd < -OUT_LIMIT) begin
            sat = -OUT_LIMIT[OUT_W-1:0];
        end else begin
            sat = rnd[OUT_W-1:0];
        end
    end

    // product staging
    always_ff @(posedge i_clk) begin
        if (i_cmd.round_fx) begin
            r_fx <= rnd[CW-1:0];
        end
        if (i_cmd.round_fz) begin
            r_fz <= rnd[CW-1:0];
        end
        if (i_cmd.hold_dx) begin
            r_dx <= sat;
        end
        if (i_cmd.hold_dy) begin
            r_dy <= sat;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_x <= r_dx;
            r_out_y <= r_dy;
            r_out_z <= sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_dir_x        = r_out_x;
    assign o_dir_y        = r_out_y;
    assign o_dir_z        = r_out_z;

    // elevation never leaves plus or minus pi/2
    a_el_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_el >= -16'sd6434) && (r_el <= 16'sd6434))
        else $error("elevation outside clamp range");

    // azimuth after a rotation lies strictly inside plus or minus 2*pi
    a_az_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_cmd.upd && (r_op == OP_ROT_AZ)) |-> ((r_az > -16'sd25736) && (r_az < 16'sd25736)))
        else $error("azimuth wrap out of range");

    // a new result beat only appears after a load command
    a_valid_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_cmd.out_load))
        else $error("output valid rose without load");

endmodule

// ===== sv/orbit_angle_to_direction.sv =====
// an accepted beat runs the angle update, a cordic run per angle, then the products
// no new beat is accepted until the previous result is in the output register; a single
// shared cordic does one rotation per cycle, and five products share one multiplier
// the next beat is accepted while a finished result waits in the output register
// reset (synchronous, active low): angles zero, radius 256, start angles zero, no result
// top level: joins oa2d_ctrl and oa2d_dp; depends on oa2d_pkg
module orbit_angle_to_direction import oa2d_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [1:0]               i_opcode,
    input  logic signed [ANG_W-1:0]  i_angle_step,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [OUT_W-1:0]  o_dir_x,
    output logic signed [OUT_W-1:0]  o_dir_y,
    output logic signed [OUT_W-1:0]  o_dir_z,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]    i_cfg_data
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // sequencer
    oa2d_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    // arithmetic and storage
    oa2d_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_opcode     (i_opcode),
        .i_angle_step (i_angle_step),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_dir_x      (o_dir_x),
        .o_dir_y      (o_dir_y),
        .o_dir_z      (o_dir_z)
    );

endmodule
